// ===== rtl/core/tcm_pkg.sv =====
// Shared types, constants and the fade curve for the crossfading tube multiplexer.
// Used by every other file in rtl/core but tcm_ram; has no dependencies of its own.
package tcm_pkg;

  // Digit positions and field widths.
  localparam int DIGIT_COUNT  = 4;
  localparam int CURVE_LENGTH = 128;
  localparam int IDX_W        = 2;
  localparam int VAL_W        = 8;
  localparam int CODE_W       = 4;
  localparam int TIME_W       = 6;
  localparam int STEP_W       = 7;
  localparam int ADDR_W       = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam int FLASH_BIT    = 7;

  localparam logic [TIME_W-1:0] FULL_TIME  = 6'h3F;
  localparam logic [CODE_W-1:0] BLANK_CODE = 4'hA;
  localparam logic [VAL_W-1:0]  BLANK_VAL  = 8'h0A;

  // Command codes.
  localparam logic CMD_SET     = 1'b0;
  localparam logic CMD_SERVICE = 1'b1;

  // Per-digit sequencing mode.
  typedef enum logic [3:0] {
    MODE_STEADY = 4'b0001,
    MODE_CROSS  = 4'b0010,
    MODE_FOUT   = 4'b0100,
    MODE_FIN    = 4'b1000
  } mode_t;

  // One entry of the digit state memory.
  typedef struct packed {
    mode_t             mode;
    logic [VAL_W-1:0]  shown;
    logic [VAL_W-1:0]  target;
    logic [STEP_W-1:0] step;
  } dstate_t;

  // One lit segment on the output.
  typedef struct packed {
    logic [IDX_W-1:0]  tube;
    logic [CODE_W-1:0] code;
    logic [TIME_W-1:0] on_time;
    logic              last;
  } seg_t;

  // Everything a single service produces.
  typedef struct packed {
    seg_t seg0;
    seg_t seg1;
    logic two;
  } slot_t;

  localparam dstate_t DSTATE_RESET = '{
    mode:   MODE_STEADY,
    shown:  BLANK_VAL,
    target: BLANK_VAL,
    step:   '0
  };
  localparam logic [VAL_W-1:0] REQ_RESET = '0;

  // Fade curve, falling from full brightness to zero.
  localparam logic [TIME_W-1:0] CURVE [128] = '{
    6'h3F, 6'h3E, 6'h3E, 6'h3E, 6'h3E, 6'h3E, 6'h3E, 6'h3E,
    6'h3E, 6'h3E, 6'h3D, 6'h3D, 6'h3D, 6'h3D, 6'h3D, 6'h3D, 6'h3D, 6'h3D,
    6'h3D, 6'h3C, 6'h3C, 6'h3C, 6'h3C, 6'h3C, 6'h3C, 6'h3C, 6'h3C, 6'h3B,
    6'h3B, 6'h3B, 6'h3B, 6'h3B, 6'h3B, 6'h3B, 6'h3A, 6'h3A, 6'h3A, 6'h3A,
    6'h3A, 6'h3A, 6'h3A, 6'h39, 6'h39, 6'h39, 6'h39, 6'h39, 6'h39, 6'h39,
    6'h38, 6'h38, 6'h38, 6'h38, 6'h38, 6'h38, 6'h37, 6'h37, 6'h37, 6'h37,
    6'h37, 6'h36, 6'h36, 6'h36, 6'h36, 6'h36, 6'h36, 6'h35, 6'h35, 6'h35,
    6'h35, 6'h34, 6'h34, 6'h34, 6'h34, 6'h34, 6'h33, 6'h33, 6'h33, 6'h33,
    6'h32, 6'h32, 6'h32, 6'h31, 6'h31, 6'h31, 6'h31, 6'h30, 6'h30, 6'h30,
    6'h2F, 6'h2F, 6'h2F, 6'h2E, 6'h2E, 6'h2E, 6'h2D, 6'h2D, 6'h2D, 6'h2C,
    6'h2C, 6'h2B, 6'h2B, 6'h2A, 6'h2A, 6'h29, 6'h29, 6'h28, 6'h28, 6'h27,
    6'h26, 6'h26, 6'h25, 6'h24, 6'h24, 6'h23, 6'h22, 6'h21, 6'h20, 6'h1F,
    6'h1D, 6'h1C, 6'h1B, 6'h19, 6'h17, 6'h14, 6'h12, 6'h0E, 6'h09, 6'h00
  };

  // Curve lookup; steps at or past the end of the curve read as zero.
  function automatic logic [TIME_W-1:0] curve_at(input logic [STEP_W-1:0] step);
    logic [TIME_W-1:0] d;
    d = CURVE[step];
    if (int'(step) >= CURVE_LENGTH - 1) begin
      d = '0;
    end
    return d;
  endfunction

endpackage

// ===== rtl/core/tcm_in_if.sv =====
// Command channel: valid/ready handshake carrying one command beat.
// Depends on tcm_pkg for field widths.
interface tcm_in_if;
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic [tcm_pkg::IDX_W-1:0]    digit_index;
  logic [tcm_pkg::VAL_W-1:0]    value;

  modport source (output valid, output cmd, output digit_index, output value, input ready);
  modport sink   (input valid, input cmd, input digit_index, input value, output ready);
endinterface

// ===== rtl/core/tcm_out_if.sv =====
// Segment channel: valid/ready handshake carrying one lit segment per beat.
// Depends on tcm_pkg for field widths.
interface tcm_out_if;
  logic                         valid;
  logic                         ready;
  logic [tcm_pkg::IDX_W-1:0]    tube_index;
  logic [tcm_pkg::CODE_W-1:0]   digit_code;
  logic [tcm_pkg::TIME_W-1:0]   on_time;
  logic                         last;

  modport source (output valid, output tube_index, output digit_code, output on_time,
                  output last, input ready);
  modport sink   (input valid, input tube_index, input digit_code, input on_time,
                  input last, output ready);
endinterface

// ===== rtl/core/tcm_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No package dependencies.
module tcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  parameter int AW    = 2
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port with registered data; returns the old data on a same-address write.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/tcm_slot_eng.sv =====
// Next-state and segment logic for one digit service slot.
// Depends on tcm_pkg for the state layout and the fade curve.
module tcm_slot_eng (
  input  tcm_pkg::dstate_t               st_cur,
  input  logic [tcm_pkg::VAL_W-1:0]      req,
  input  logic [tcm_pkg::IDX_W-1:0]      tube,
  output tcm_pkg::dstate_t               st_nxt,
  output tcm_pkg::slot_t                 slot
);

  logic [tcm_pkg::TIME_W-1:0] d;
  logic [tcm_pkg::TIME_W-1:0] rest;
  logic                       d_zero;

  assign d      = tcm_pkg::curve_at(st_cur.step);
  assign rest   = tcm_pkg::FULL_TIME - d;
  assign d_zero = (d == '0);

  // Advance the digit's mode and build its one or two segments.
  always_comb begin
    st_nxt           = st_cur;
    st_nxt.step      = st_cur.step + 1'b1;
    slot.two         = 1'b1;
    slot.seg0.tube   = tube;
    slot.seg0.code   = st_cur.shown[tcm_pkg::CODE_W-1:0];
    slot.seg0.on_time = d;
    slot.seg0.last   = 1'b0;
    slot.seg1.tube   = tube;
    slot.seg1.code   = tcm_pkg::BLANK_CODE;
    slot.seg1.on_time = rest;
    slot.seg1.last   = 1'b1;
    case (st_cur.mode)
      tcm_pkg::MODE_CROSS: begin
        if (d_zero) begin
          st_nxt.shown = st_cur.target;
          st_nxt.mode  = tcm_pkg::MODE_STEADY;
          st_nxt.step  = '0;
        end
        slot.seg0.code = st_nxt.shown[tcm_pkg::CODE_W-1:0];
        slot.seg1.code = st_cur.target[tcm_pkg::CODE_W-1:0];
      end
      tcm_pkg::MODE_FOUT: begin
        if (d_zero) begin
          st_nxt.mode       = tcm_pkg::MODE_FIN;
          st_nxt.shown      = st_cur.target;
          st_nxt.step       = '0;
          slot.two          = 1'b0;
          slot.seg0.code    = tcm_pkg::BLANK_CODE;
          slot.seg0.on_time = tcm_pkg::FULL_TIME;
          slot.seg0.last    = 1'b1;
        end
      end
      tcm_pkg::MODE_FIN: begin
        if (d_zero) begin
          st_nxt.mode = (st_cur.shown != st_cur.target) ? tcm_pkg::MODE_CROSS
                                                        : tcm_pkg::MODE_FOUT;
          st_nxt.step       = '0;
          slot.two          = 1'b0;
          slot.seg0.on_time = tcm_pkg::FULL_TIME;
          slot.seg0.last    = 1'b1;
        end else begin
          slot.seg0.code = tcm_pkg::BLANK_CODE;
          slot.seg1.code = st_cur.shown[tcm_pkg::CODE_W-1:0];
        end
      end
      default: begin
        // Steady: pick up a new request and start a fade toward it.
        st_nxt.step = st_cur.step;
        if (st_cur.target != req) begin
          st_nxt.target = req;
          st_nxt.mode   = req[tcm_pkg::FLASH_BIT] ? tcm_pkg::MODE_FOUT
                                                  : tcm_pkg::MODE_CROSS;
          st_nxt.step   = '0;
        end
        slot.two          = 1'b0;
        slot.seg0.on_time = tcm_pkg::FULL_TIME;
        slot.seg0.last    = 1'b1;
      end
    endcase
  end

endmodule

// ===== rtl/core/tcm_out_buf.sv =====
// Two-segment output register that hands segments out one beat at a time.
// Depends on tcm_pkg and tcm_out_if.
module tcm_out_buf (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  tcm_pkg::slot_t  slot,
  output logic            can_load,
  tcm_out_if.source       out_bus
);

  tcm_pkg::seg_t seg0_r;
  tcm_pkg::seg_t seg1_r;
  logic [1:0]    cnt_r;
  logic [1:0]    cnt_nxt;
  logic          pop;

  assign pop      = out_bus.valid && out_bus.ready;
  assign can_load = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && pop);

  // Count of segments still held.
  always_comb begin
    cnt_nxt = cnt_r;
    if (load) begin
      cnt_nxt = slot.two ? 2'd2 : 2'd1;
    end else if (pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Segment payload: load a fresh pair, or shift the second one forward.
  always_ff @(posedge clk) begin
    if (load) begin
      seg0_r <= slot.seg0;
      seg1_r <= slot.seg1;
    end else if (pop) begin
      seg0_r <= seg1_r;
    end
  end

  assign out_bus.valid      = (cnt_r != 2'd0);
  assign out_bus.tube_index = seg0_r.tube;
  assign out_bus.digit_code = seg0_r.code;
  assign out_bus.on_time    = seg0_r.on_time;
  assign out_bus.last       = seg0_r.last;

endmodule

// ===== rtl/core/tube_crossfade_multiplexer_top.sv =====
// Top level of the crossfading tube multiplexer.
// Depends on tcm_pkg, tcm_in_if, tcm_out_if, tcm_ram, tcm_slot_eng and tcm_out_buf.
//
// Usage:
//   in_bus carries commands. A set beat (cmd 0) stores a requested value for
//   the digit counted from the other end and produces no output. A service
//   beat (cmd 1) runs one display slot of the addressed digit and produces
//   one or two segment beats on out_bus; the final one has last set.
//   Beats addressing a position beyond the digit count are dropped.
//   A service's first segment is offered from the output register once the
//   slot computed in stage 1 is loaded there. A service holds stage 1 until
//   the two-segment output register is empty or its final segment is being
//   taken; that register is the limit. Set beats go at one per cycle unless a
//   waiting service holds stage 1. Digit state is read from RAM at the
//   accepting edge and written back as its slot loads, with back-to-back forwarding.
//   Reset: all digits come up steady and blank with zero requests; per-entry
//   valid bits stand in for the RAM contents, so no clearing pass is needed.
//   When out_bus stalls, the held segments wait and in_bus drops ready once
//   a service beat is waiting for the output register.
module tube_crossfade_multiplexer_top (
  input  logic       clk,
  input  logic       rst_n,
  tcm_in_if.sink     in_bus,
  tcm_out_if.source  out_bus
);

  localparam int AW = tcm_pkg::ADDR_W;
  localparam int DC = tcm_pkg::DIGIT_COUNT;

  // Stage-1 command register.
  logic                        s1_valid_r;
  logic                        s1_cmd_r;
  logic [tcm_pkg::IDX_W-1:0]   s1_idx_r;
  logic [tcm_pkg::VAL_W-1:0]   s1_val_r;
  logic                        s1_in_range_r;
  logic [AW-1:0]               s1_addr;
  logic                        s1_service;
  logic                        s1_done;
  logic                        in_acc;
  logic                        in_range;
  logic [AW-1:0]               in_addr;

  // Memory ports and forwarding.
  tcm_pkg::dstate_t            st_q;
  tcm_pkg::dstate_t            st_cur;
  tcm_pkg::dstate_t            st_nxt;
  tcm_pkg::dstate_t            st_fwd_r;
  logic                        st_fwd_hit_r;
  logic                        st_we;
  logic [DC-1:0]               st_vld_r;
  logic [tcm_pkg::VAL_W-1:0]   rq_q;
  logic [tcm_pkg::VAL_W-1:0]   rq_cur;
  logic [tcm_pkg::VAL_W-1:0]   rq_fwd_r;
  logic                        rq_fwd_hit_r;
  logic                        rq_we;
  logic [AW-1:0]               rq_waddr;
  logic [DC-1:0]               rq_vld_r;

  tcm_pkg::slot_t              slot;
  logic                        can_load;

  // Input handshake and address decode.
  assign in_range     = int'(in_bus.digit_index) < DC;
  assign in_addr      = AW'(in_bus.digit_index);
  assign s1_addr      = AW'(s1_idx_r);
  assign s1_service   = (s1_cmd_r == tcm_pkg::CMD_SERVICE) && s1_in_range_r;
  assign s1_done      = s1_valid_r && (!s1_service || can_load);
  assign in_bus.ready = !s1_valid_r || s1_done;
  assign in_acc       = in_bus.valid && in_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      s1_valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r      <= in_bus.cmd;
      s1_idx_r      <= in_bus.digit_index;
      s1_val_r      <= in_bus.value;
      s1_in_range_r <= in_range;
    end
  end

  // Write-back enables; set commands go to the mirrored position.
  assign st_we    = s1_valid_r && s1_service && can_load;
  assign rq_we    = s1_valid_r && (s1_cmd_r == tcm_pkg::CMD_SET) && s1_in_range_r;
  assign rq_waddr = AW'(DC - 1 - int'(s1_idx_r));

  // Digit state and request memories.
  tcm_ram #(.WIDTH($bits(tcm_pkg::dstate_t)), .DEPTH(DC), .AW(AW)) u_state_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (s1_addr),
    .wdata (st_nxt),
    .re    (in_acc),
    .raddr (in_addr),
    .rdata (st_q)
  );

  tcm_ram #(.WIDTH(tcm_pkg::VAL_W), .DEPTH(DC), .AW(AW)) u_req_ram (
    .clk   (clk),
    .we    (rq_we),
    .waddr (rq_waddr),
    .wdata (s1_val_r),
    .re    (in_acc),
    .raddr (in_addr),
    .rdata (rq_q)
  );

  // Capture a write that lands on the entry being read in the same cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_fwd_hit_r <= 1'b0;
      rq_fwd_hit_r <= 1'b0;
    end else if (in_acc) begin
      st_fwd_hit_r <= st_we && (s1_addr == in_addr);
      rq_fwd_hit_r <= rq_we && (rq_waddr == in_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      st_fwd_r <= st_nxt;
      rq_fwd_r <= s1_val_r;
    end
  end

  // Entries never written read as their reset values.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_vld_r <= '0;
      rq_vld_r <= '0;
    end else begin
      if (st_we) begin
        st_vld_r[s1_addr] <= 1'b1;
      end
      if (rq_we) begin
        rq_vld_r[rq_waddr] <= 1'b1;
      end
    end
  end

  always_comb begin
    st_cur = tcm_pkg::DSTATE_RESET;
    if (st_fwd_hit_r) begin
      st_cur = st_fwd_r;
    end else if (st_vld_r[s1_addr]) begin
      st_cur = st_q;
    end
  end

  always_comb begin
    rq_cur = tcm_pkg::REQ_RESET;
    if (rq_fwd_hit_r) begin
      rq_cur = rq_fwd_r;
    end else if (rq_vld_r[s1_addr]) begin
      rq_cur = rq_q;
    end
  end

  // Slot computation and output register.
  tcm_slot_eng u_eng (
    .st_cur (st_cur),
    .req    (rq_cur),
    .tube   (s1_idx_r),
    .st_nxt (st_nxt),
    .slot   (slot)
  );

  tcm_out_buf u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (st_we),
    .slot     (slot),
    .can_load (can_load),
    .out_bus  (out_bus)
  );

`ifndef NO_ASSERTIONS
  // A completed service always leaves a segment on the output.
  a_service_emits: assert property (@(posedge clk) disable iff (!rst_n)
    st_we |=> out_bus.valid)
    else $error("service completed without an output segment");

  // Input is held off only by a service waiting on the output register.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_bus.ready |-> (s1_valid_r && s1_service && !can_load))
    else $error("input stalled without a waiting service");

  // A slot writes either the state memory or the request memory, never both.
  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    !(st_we && rq_we))
    else $error("state and request written by one beat");
`endif

endmodule
